@@ rtl/tpef_pkg.sv @@
// tpef_pkg: shared widths, register indexes, status codes and reset values
// for the trace pulse edge finder. No dependencies.
`default_nettype none

package tpef_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 11;
    localparam int DELTA_W  = 16;
    localparam int OFFSET_W = 10;
    localparam int STATUS_W = 2;
    localparam int EDGE_W   = 6;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_DELTA  = 1'b1;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 11'd1024;
    localparam logic [DELTA_W-1:0] DELTA_RESET  = 16'd500;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EDGE_CAP = 2'd2;

endpackage

`default_nettype wire

@@ rtl/trace_pulse_edge_finder.sv @@
// trace_pulse_edge_finder: top level, trace buffer memory, min/max tracking,
// backward threshold scan and result register. Depends on tpef_pkg.
//
// Usage: samples of one trace enter on the s_ channel, one item per cycle
// while s_ready is high; s_last_sample marks the final sample. s_ready drops
// after the last sample until the trace's closing record has been loaded
// into the result register. Results leave on the m_ channel: zero or more
// edge items (m_edge_valid high) and then one closing item (m_last high)
// that carries the status.
// Sequence: after the last sample the ST_DECIDE state decides the trace; a
// trace that passes the length and spread checks is then scanned backward
// through the buffer memory, one stored sample per cycle unless a stall holds
// the scan (the single read port of the trace buffer sets this rate), then
// the closing item is loaded.
// Stalls: when an edge item is due while the result register holds an untaken
// item, the scan holds its place and resumes without loss once it frees.
// Reset: aresetn (synchronous, active low) clears the trace state and sets
// window_size to 1024 and delta to 500. The trace buffer is not cleared and
// needs no clearing pass; only samples of the current trace are read.
`default_nettype none

module trace_pulse_edge_finder #(
    parameter int TRACE_DEPTH = 1024,
    parameter int MAX_EDGES   = 63
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // sample channel
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [tpef_pkg::SAMPLE_W-1:0] s_sample,
    input  wire logic                                 s_last_sample,
    // result channel
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [tpef_pkg::OFFSET_W-1:0]             m_edge_offset,
    output logic                                      m_edge_valid,
    output logic [tpef_pkg::STATUS_W-1:0]             m_status,
    output logic                                      m_last,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tpef_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [tpef_pkg::DATA_W-1:0]          pwdata,
    output logic [tpef_pkg::DATA_W-1:0]               prdata,
    output logic                                      pready
);
    import tpef_pkg::*;

    localparam int AW   = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
    localparam int CW   = $clog2(TRACE_DEPTH + 2);
    localparam int CMPW = (CW > WIN_W) ? CW : WIN_W;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DECIDE,
        ST_SCAN,
        ST_CLOSE
    } state_t;

    // trace buffer
    logic [SAMPLE_W-1:0] trace_mem [TRACE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_en;
    logic                wr_en;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic                 spread_reg, spread_next;
    logic                 armed_reg, armed_next;
    logic [EDGE_W-1:0]    edge_cnt_reg, edge_cnt_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic signed [SAMPLE_W+1:0] thr_reg, thr_next;
    logic [AW-1:0]        rd_addr_reg, rd_addr_next;
    logic                 issue_more_reg, issue_more_next;
    logic                 proc_valid_reg, proc_valid_next;
    logic [OFFSET_W-1:0]  off_reg, off_next;
    logic [WIN_W-1:0]     window_reg, window_next;
    logic [DELTA_W-1:0]   delta_reg, delta_next;

    logic                 m_valid_reg, m_valid_next;
    logic [OFFSET_W-1:0]  m_offset_reg, m_offset_next;
    logic                 m_edge_reg, m_edge_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic                 m_last_reg, m_last_next;

    // load path
    logic                       s_acc;
    logic                       seed;
    logic signed [SAMPLE_W-1:0] mn_base, mx_base, mn_new, mx_new;
    logic [SAMPLE_W:0]          spread_diff;
    logic                       spread_new;

    // scan path
    logic signed [SAMPLE_W+1:0] s_ext;
    logic                       below, above;
    logic                       hit, ovf, emit, stall, out_free;
    logic                       wrong_len;
    logic                       apb_wr;

    assign s_ready  = (state_reg == ST_LOAD);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign apb_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    assign seed    = (min_reg == '0) && (max_reg == '0);
    assign mn_base = seed ? s_sample : min_reg;
    assign mx_base = seed ? s_sample : max_reg;
    assign mn_new  = (s_sample < mn_base) ? s_sample : mn_base;
    assign mx_new  = (s_sample > mx_base) ? s_sample : mx_base;
    // max >= min, so the difference is never negative
    assign spread_diff = {mx_new[SAMPLE_W-1], mx_new} - {mn_new[SAMPLE_W-1], mn_new};
    assign spread_new  = spread_diff > {1'b0, delta_reg};

    assign wrong_len = (CMPW'(count_reg) != CMPW'(window_reg))
                    || (count_reg > CW'(TRACE_DEPTH));

    assign s_ext = {{2{rd_data_reg[SAMPLE_W-1]}}, rd_data_reg};
    assign below = s_ext < thr_reg;
    assign above = s_ext > thr_reg;
    assign hit   = (state_reg == ST_SCAN) && proc_valid_reg && below && !armed_reg;
    assign ovf   = hit && (edge_cnt_reg >= EDGE_W'(MAX_EDGES));
    assign emit  = hit && !ovf;
    assign stall = emit && !out_free;
    assign rd_en = (state_reg == ST_SCAN) && issue_more_reg && !stall && !ovf;
    assign wr_en = s_acc && (count_reg < CW'(TRACE_DEPTH));

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        spread_next     = spread_reg;
        armed_next      = armed_reg;
        edge_cnt_next   = edge_cnt_reg;
        status_next     = status_reg;
        thr_next        = thr_reg;
        rd_addr_next    = rd_addr_reg;
        issue_more_next = issue_more_reg;
        proc_valid_next = proc_valid_reg;
        off_next        = off_reg;
        window_next     = window_reg;
        delta_next      = delta_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_offset_next   = m_offset_reg;
        m_edge_next     = m_edge_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;

        if (apb_wr) begin
            unique case (paddr[2])
                REG_WINDOW: window_next = pwdata[WIN_W-1:0];
                REG_DELTA:  delta_next  = pwdata[DELTA_W-1:0];
                default:    ;
            endcase
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (!spread_reg) begin
                        min_next    = mn_new;
                        max_next    = mx_new;
                        spread_next = spread_new;
                    end
                    // saturates one past the buffer depth
                    if (count_reg <= CW'(TRACE_DEPTH)) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (s_last_sample) begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (wrong_len) begin
                    status_next = STATUS_BAD_LEN;
                    state_next  = ST_CLOSE;
                end else if (spread_reg) begin
                    status_next     = STATUS_OK;
                    thr_next        = {max_reg[SAMPLE_W-1], max_reg[SAMPLE_W-1], max_reg}
                                    - {2'b00, delta_reg};
                    rd_addr_next    = AW'(window_reg - 1'b1);
                    issue_more_next = 1'b1;
                    proc_valid_next = 1'b0;
                    off_next        = '0;
                    state_next      = ST_SCAN;
                end else begin
                    status_next = STATUS_OK;
                    state_next  = ST_CLOSE;
                end
            end
            ST_SCAN: begin
                if (ovf) begin
                    status_next     = STATUS_EDGE_CAP;
                    issue_more_next = 1'b0;
                    proc_valid_next = 1'b0;
                    state_next      = ST_CLOSE;
                end else if (!stall) begin
                    if (proc_valid_reg) begin
                        off_next = off_reg + 1'b1;
                        if (emit) begin
                            armed_next    = 1'b1;
                            edge_cnt_next = edge_cnt_reg + 1'b1;
                            m_valid_next  = 1'b1;
                            m_offset_next = off_reg;
                            m_edge_next   = 1'b1;
                            m_status_next = STATUS_OK;
                            m_last_next   = 1'b0;
                        end else if (above && armed_reg) begin
                            armed_next = 1'b0;
                        end
                    end
                    proc_valid_next = rd_en;
                    if (rd_en) begin
                        rd_addr_next    = rd_addr_reg - 1'b1;
                        issue_more_next = (rd_addr_reg != '0);
                    end
                    if (!issue_more_reg) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_offset_next = '0;
                    m_edge_next   = 1'b0;
                    m_status_next = status_reg;
                    m_last_next   = 1'b1;
                    count_next    = '0;
                    min_next      = '0;
                    max_next      = '0;
                    spread_next   = 1'b0;
                    armed_next    = 1'b0;
                    edge_cnt_next = '0;
                    state_next    = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            spread_reg     <= 1'b0;
            armed_reg      <= 1'b0;
            edge_cnt_reg   <= '0;
            status_reg     <= STATUS_OK;
            issue_more_reg <= 1'b0;
            proc_valid_reg <= 1'b0;
            window_reg     <= WINDOW_RESET;
            delta_reg      <= DELTA_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            spread_reg     <= spread_next;
            armed_reg      <= armed_next;
            edge_cnt_reg   <= edge_cnt_next;
            status_reg     <= status_next;
            issue_more_reg <= issue_more_next;
            proc_valid_reg <= proc_valid_next;
            window_reg     <= window_next;
            delta_reg      <= delta_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        thr_reg      <= thr_next;
        rd_addr_reg  <= rd_addr_next;
        off_reg      <= off_next;
        m_offset_reg <= m_offset_next;
        m_edge_reg   <= m_edge_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    // trace buffer: one write port for loading, one registered read port for the scan
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            trace_mem[count_reg[AW-1:0]] <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= trace_mem[rd_addr_reg];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WINDOW: prdata = {{(DATA_W-WIN_W){1'b0}}, window_reg};
            REG_DELTA:  prdata = {{(DATA_W-DELTA_W){1'b0}}, delta_reg};
            default:    prdata = '0;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_edge_offset = m_offset_reg;
    assign m_edge_valid  = m_edge_reg;
    assign m_status      = m_status_reg;
    assign m_last        = m_last_reg;

    // a held sample must not be overwritten while its edge item waits
    a_stall_holds_data: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> $stable(rd_data_reg))
        else $error("scan data changed during output stall");

    a_edge_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_cnt_reg <= EDGE_W'(MAX_EDGES))
        else $error("edge count above cap");

    a_edge_item_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_edge_valid) |-> (m_status == STATUS_OK && !m_last))
        else $error("edge item carries closing fields");

    a_no_load_during_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_valid_reg || issue_more_reg) |-> !s_ready)
        else $error("sample accepted while scan in progress");

endmodule

`default_nettype wire

@@ sim/trace_edge_checker.sv @@
// trace_edge_checker: watches the sample, result and configuration ports of
// trace_pulse_edge_finder, predicts the edge and closing items and compares them.
// Depends on tpef_pkg.

module trace_edge_checker #(
    parameter int TRACE_DEPTH = 1024,
    parameter int MAX_EDGES   = 63
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [tpef_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_last_sample,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [tpef_pkg::OFFSET_W-1:0]        m_edge_offset,
    input  logic                                 m_edge_valid,
    input  logic [tpef_pkg::STATUS_W-1:0]        m_status,
    input  logic                                 m_last,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [tpef_pkg::PADDR_W-1:0]         paddr,
    input  logic [tpef_pkg::DATA_W-1:0]          pwdata,
    output int                                   failures,
    output int                                   due_count
);
    import tpef_pkg::*;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic                edge_valid;
        logic [STATUS_W-1:0] status;
        logic                closing;
    } edge_record_t;

    logic signed [SAMPLE_W-1:0] trace_copy [TRACE_DEPTH];
    int                         taken;
    int                         lo_val;
    int                         hi_val;
    bit                         spread_hit;
    logic [WIN_W-1:0]           window_reg;
    logic [DELTA_W-1:0]         delta_reg;
    edge_record_t               edges_due [$];
    edge_record_t               want;
    edge_record_t               got;

    task automatic clear_trace();
        taken      = 0;
        lo_val     = 0;
        hi_val     = 0;
        spread_hit = 1'b0;
    endtask

    // one accepted sample; on the last sample of a trace this queues the
    // edge items of the backward scan and the closing item
    task automatic predict_edges(input logic signed [SAMPLE_W-1:0] smp, input logic is_end);
        int           v;
        int           thr;
        int           idx;
        int           back_off;
        int           n_edges;
        bit           armed;
        edge_record_t rec;
        edge_record_t hit_rec;
        v = smp;
        if (!spread_hit) begin
            // both zero means nothing seen yet, so re-seed from this sample
            if (lo_val == 0 && hi_val == 0) begin
                lo_val = v;
                hi_val = v;
            end
            if (v < lo_val) lo_val = v;
            if (v > hi_val) hi_val = v;
            if (hi_val - lo_val > int'(delta_reg)) spread_hit = 1'b1;
        end
        if (taken < TRACE_DEPTH) trace_copy[taken] = smp;
        if (taken <= TRACE_DEPTH) taken++;
        if (is_end) begin
            rec.status = STATUS_OK;
            armed      = 1'b0;
            n_edges    = 0;
            if (taken != int'(window_reg) || taken > TRACE_DEPTH) begin
                rec.status = STATUS_BAD_LEN;
            end else if (spread_hit) begin
                thr = hi_val - int'(delta_reg);
                for (idx = int'(window_reg) - 1; idx >= 0; idx--) begin
                    v = trace_copy[idx];
                    if (v < thr && !armed) begin
                        if (n_edges >= MAX_EDGES) begin
                            rec.status = STATUS_EDGE_CAP;
                            break;
                        end
                        back_off           = int'(window_reg) - 1 - idx;
                        hit_rec.offset     = back_off[OFFSET_W-1:0];
                        hit_rec.edge_valid = 1'b1;
                        hit_rec.status     = STATUS_OK;
                        hit_rec.closing    = 1'b0;
                        edges_due          = {edges_due, hit_rec};
                        n_edges++;
                        armed = 1'b1;
                    end
                    if (v > thr && armed) armed = 1'b0;
                end
            end
            rec.offset     = '0;
            rec.edge_valid = 1'b0;
            rec.closing    = 1'b1;
            edges_due      = {edges_due, rec};
            clear_trace();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_trace();
            window_reg = WINDOW_RESET;
            delta_reg  = DELTA_RESET;
            edges_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_WINDOW: window_reg = pwdata[WIN_W-1:0];
                    REG_DELTA:  delta_reg  = pwdata[DELTA_W-1:0];
                endcase
            end
            if (s_valid && s_ready) predict_edges(s_sample, s_last_sample);
            if (m_valid && m_ready) begin
                got = {m_edge_offset, m_edge_valid, m_status, m_last};
                if (edges_due.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected item off=%0d edge=%0b status=%0d last=%0b",
                             $time, got.offset, got.edge_valid, got.status, got.closing);
                end else begin
                    want = edges_due.pop_front();
                    if (got.offset !== want.offset || got.edge_valid !== want.edge_valid ||
                        got.status !== want.status || got.closing !== want.closing) begin
                        failures++;
                        $display("%0t: mismatch, expected off=%0d edge=%0b status=%0d last=%0b, %s",
                                 $time, want.offset, want.edge_valid, want.status, want.closing,
                                 $sformatf("got off=%0d edge=%0b status=%0d last=%0b",
                                           got.offset, got.edge_valid, got.status, got.closing));
                    end
                end
            end
        end
        due_count = edges_due.size();
    end

endmodule

@@ sim/trace_pulse_edge_finder_tb.sv @@
// trace_pulse_edge_finder_tb: clock, reset, sample traces, register writes
// and receiver stalls for trace_pulse_edge_finder; checking is done by
// trace_edge_checker. Depends on tpef_pkg and both of those modules.

module trace_pulse_edge_finder_tb;
    import tpef_pkg::*;

    typedef enum int {SHAPE_PULSES, SHAPE_TOGGLE, SHAPE_NOISE, SHAPE_FLAT} shape_t;

    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 2100;
    localparam int HOLD_CYCLES  = 400;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_valid       = 1'b0;
    logic signed [SAMPLE_W-1:0] s_sample     = '0;
    logic                      s_last_sample = 1'b0;
    logic                      m_ready       = 1'b0;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [PADDR_W-1:0]        paddr         = '0;
    logic [DATA_W-1:0]         pwdata        = '0;
    logic                      s_ready;
    logic                      m_valid;
    logic [OFFSET_W-1:0]       m_edge_offset;
    logic                      m_edge_valid;
    logic [STATUS_W-1:0]       m_status;
    logic                      m_last;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int cur_window = 1024;
    int quiet      = 0;
    int hold_left  = 0;
    int failures;
    int due_count;
    bit hold_req   = 1'b0;
    bit hold_seen  = 1'b0;

    always #5 aclk = ~aclk;

    trace_pulse_edge_finder #(
        .TRACE_DEPTH(1024),
        .MAX_EDGES  (63)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_last_sample(s_last_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_offset(m_edge_offset),
        .m_edge_valid (m_edge_valid),
        .m_status     (m_status),
        .m_last       (m_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    trace_edge_checker #(
        .TRACE_DEPTH(1024),
        .MAX_EDGES  (63)
    ) edge_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_last_sample(s_last_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_offset(m_edge_offset),
        .m_edge_valid (m_edge_valid),
        .m_status     (m_status),
        .m_last       (m_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .failures     (failures),
        .due_count    (due_count)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample      <= smp;
        s_last_sample <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // wait until every closing item is out, so the block is idle
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (due_count != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // upper data bits are junk, only the register's own width counts
    task automatic reconfigure(input int win, input logic [DELTA_W-1:0] dlt);
        logic [31:0] junk;
        settle();
        junk = $urandom();
        write_reg(REG_WINDOW, {junk[31:WIN_W], win[WIN_W-1:0]});
        write_reg(REG_DELTA, {junk[31:DELTA_W], dlt});
        cur_window = win;
    endtask

    function automatic logic [DELTA_W-1:0] pick_delta();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd65535;
            2, 3:    return 16'($urandom_range(1, 50));
            default: return 16'($urandom_range(100, 3000));
        endcase
    endfunction

    task automatic send_trace(input int len, input shape_t shape);
        int                         base;
        int                         amp;
        int                         zeros;
        int                         k;
        bit                         dip;
        logic [31:0]                r;
        logic signed [SAMPLE_W-1:0] smp;
        base  = int'($urandom_range(0, 2000)) - 1000;
        amp   = $urandom_range(0, 3000);
        // a few leading zeros keep min and max re-seeding
        zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        dip   = 1'b0;
        for (k = 0; k < len; k++) begin
            r = $urandom();
            case (shape)
                SHAPE_PULSES: begin
                    if ($urandom_range(0, 4) == 0) dip = !dip;
                    smp = (k < zeros) ? 16'sd0
                                      : 16'(base - (dip ? amp : 0) + int'(r[3:0]) - 8);
                end
                SHAPE_TOGGLE: smp = k[0] ? -16'sd1000 : 16'sd1000;
                SHAPE_NOISE:  smp = r[SAMPLE_W-1:0];
                default:      smp = (k < zeros) ? 16'sd0 : 16'(base);
            endcase
            send_item(smp, k == len - 1);
        end
    endtask

    initial begin
        int     ph;
        int     sent;
        int     sel;
        int     len;
        shape_t shape;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short trace under the reset register values
        send_trace(3, SHAPE_PULSES);

        // zero re-seed, both sample extremes, edges at scan offsets 0 and 2
        reconfigure(4, 16'd500);
        send_item(16'sd0, 1'b0);
        send_item(16'sd0, 1'b0);
        send_item(16'h7fff, 1'b0);
        send_item(16'h8000, 1'b1);
        // trace too short
        send_item(16'sd100, 1'b0);
        send_item(-16'sd100, 1'b1);
        // samples equal to the threshold leave the arming alone
        reconfigure(3, 16'd0);
        send_item(16'sd5, 1'b0);
        send_item(16'sd1, 1'b0);
        send_item(16'sd5, 1'b1);
        // single sample never reaches the spread
        reconfigure(1, 16'd0);
        send_item(16'sd7, 1'b1);
        reconfigure(0, 16'd0);
        send_item(16'sd123, 1'b1);
        // full-scale swing still short of the largest delta
        reconfigure(2, 16'd65535);
        send_item(16'h8000, 1'b0);
        send_item(16'h7fff, 1'b1);
        reconfigure(2047, 16'd65535);
        send_item(-16'sd1, 1'b1);
        // trace too long
        reconfigure(3, 16'd20);
        send_item(16'sd300, 1'b0);
        send_item(-16'sd300, 1'b0);
        send_item(16'sd300, 1'b0);
        send_item(-16'sd300, 1'b1);

        for (ph = 0; ph < 8; ph++) begin
            case (ph / 2)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 83; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            reconfigure($urandom_range(1, 24), pick_delta());
            // long receiver hold while traces keep coming, fills the block
            if (ph == 1) hold_req = !hold_req;
            sent = 0;
            while (sent < 27) begin
                sel = $urandom_range(0, 99);
                len = cur_window;
                if (sel >= 86) begin
                    len = (cur_window > 1 && sel[0]) ?
                          cur_window - $urandom_range(1, cur_window - 1) :
                          cur_window + $urandom_range(1, 3);
                end
                if (sel < 55 || (sel >= 86 && sel < 93)) shape = SHAPE_PULSES;
                else if (sel < 70)                       shape = SHAPE_TOGGLE;
                else if (sel < 78 || sel >= 93)          shape = SHAPE_NOISE;
                else                                     shape = SHAPE_FLAT;
                send_trace(len, shape);
                sent += len;
            end
        end

        idle_pct  = 0;
        stall_pct = 20;
        // the edge limit is reached and one more edge is due
        reconfigure(128, 16'd10);
        send_trace(128, SHAPE_TOGGLE);
        reconfigure(5, 16'd100);
        send_trace(5, SHAPE_PULSES);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
